// ===== hdl/dsa_pkg.sv =====
// Shared types and constants for the descriptor slot allocator.
`default_nettype none

package dsa_pkg;

  typedef enum logic [2:0] {
    ACT_BIND     = 3'd0,
    ACT_RELEASE  = 3'd1,
    ACT_VALIDATE = 3'd2,
    ACT_FETCH    = 3'd3,
    ACT_POST     = 3'd4,
    ACT_CLEAR    = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_ABSENT   = 2'd3
  } status_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPTIONS_MASK = 2'd2;

  localparam int ENABLE_W  = 4;
  localparam int LIMIT_W   = 7;
  localparam int IFACE_W   = 3;
  localparam int SLOT_W    = 6;
  localparam int ADDR64_W  = 64;
  localparam int OPTIONS_W = 16;
  localparam int DESC_W    = 2 * ADDR64_W + OPTIONS_W;

  localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 7'd64;
  localparam logic [OPTIONS_W-1:0] OPTIONS_RESET = 16'hFFFF;

  // Busy bits examined per scan step.
  localparam int CHUNK = 8;

endpackage

`default_nettype wire

// ===== hdl/dsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/descriptor_slot_allocator.sv =====
// Descriptor slot allocator: per-interface slot tables with reference counts.
// Sequence: an accepted item goes from the check step to the done step for checks, validate
// and fetch; release, post and clear add a count read step; a bind scans busy bits in groups
// of 8 until it grants the lowest free slot or passes the limit. The next item is taken in the
// cycle after the result is loaded, not before; a stalled result holds it longer.
// Reset: config to defaults, every slot free; memories keep contents (count zeroed on bind).
`default_nettype none

module descriptor_slot_allocator #(
  parameter int NUM_INTERFACES      = 4,
  parameter int SLOTS_PER_INTERFACE = 64,
  parameter int COUNT_WIDTH         = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [2:0]                          in_action,
  input  wire logic [dsa_pkg::IFACE_W-1:0]         in_interface_req,
  input  wire logic                                in_handle_kind_ok,
  input  wire logic [dsa_pkg::SLOT_W-1:0]          in_slot,
  input  wire logic [dsa_pkg::ADDR64_W-1:0]        in_start_address,
  input  wire logic [dsa_pkg::ADDR64_W-1:0]        in_buffer_length,
  input  wire logic [dsa_pkg::OPTIONS_W-1:0]       in_option_bits,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               out_status,
  output logic [dsa_pkg::SLOT_W-1:0]               out_assigned_slot,
  output logic [dsa_pkg::ADDR64_W-1:0]             out_read_start,
  output logic [dsa_pkg::ADDR64_W-1:0]             out_read_length,
  output logic [dsa_pkg::OPTIONS_W-1:0]            out_read_options,
  // configuration
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dsa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dsa_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int TOTAL   = NUM_INTERFACES * SLOTS_PER_INTERFACE;
  localparam int AW      = TOTAL > 1 ? $clog2(TOTAL) : 1;
  localparam int IW      = NUM_INTERFACES > 1 ? $clog2(NUM_INTERFACES) : 1;
  localparam int LW      = $clog2(SLOTS_PER_INTERFACE + 1) > dsa_pkg::LIMIT_W ?
                           $clog2(SLOTS_PER_INTERFACE + 1) : dsa_pkg::LIMIT_W;
  localparam int KW      = LW + 3;
  localparam int XW      = (AW > KW ? AW : KW) + 1;
  localparam int NCHUNK  = (SLOTS_PER_INTERFACE + dsa_pkg::CHUNK - 1) / dsa_pkg::CHUNK;
  localparam int CW      = NCHUNK > 1 ? $clog2(NCHUNK) : 1;
  localparam int CSH     = $clog2(dsa_pkg::CHUNK);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_SCAN  = 5'b00100,
    S_READ  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // control
  state_t                          state_r, state_nxt;
  logic [CW-1:0]                   chunk_r, chunk_nxt;
  logic [TOTAL-1:0]                busy_r, busy_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [dsa_pkg::ENABLE_W-1:0]    en_mask_r;
  logic [dsa_pkg::LIMIT_W-1:0]     limit_r;
  logic [dsa_pkg::OPTIONS_W-1:0]   opt_mask_r;

  // latched item and result
  dsa_pkg::action_t                action_r;
  logic [dsa_pkg::IFACE_W-1:0]     iface_r;
  logic                            kind_ok_r;
  logic [dsa_pkg::SLOT_W-1:0]      slot_r;
  logic [dsa_pkg::ADDR64_W-1:0]    start_r;
  logic [dsa_pkg::ADDR64_W-1:0]    length_r;
  logic [dsa_pkg::OPTIONS_W-1:0]   opts_r;
  dsa_pkg::status_t                res_status_r, res_status_nxt;
  logic [dsa_pkg::SLOT_W-1:0]      res_slot_r, res_slot_nxt;
  logic                            res_fetch_r, res_fetch_nxt;

  logic [1:0]                      out_status_r;
  logic [dsa_pkg::SLOT_W-1:0]      out_slot_r;
  logic [dsa_pkg::ADDR64_W-1:0]    out_start_r;
  logic [dsa_pkg::ADDR64_W-1:0]    out_length_r;
  logic [dsa_pkg::OPTIONS_W-1:0]   out_options_r;

  logic                            in_xfer;
  logic                            out_load;

  // decode
  logic [LW-1:0]                   lim;
  logic                            iface_ok;
  logic                            enabled;
  logic [2*dsa_pkg::ENABLE_W-1:0]  en_vec;
  logic [AW-1:0]                   base;
  logic [AW-1:0]                   idx;
  logic                            slot_ok;
  logic                            opts_bad;

  // scanner
  logic [KW-1:0]                   scan_k [dsa_pkg::CHUNK];
  logic [dsa_pkg::CHUNK-1:0]       scan_free;
  logic [CSH-1:0]                  hit_j;
  logic                            scan_hit;
  logic [KW-1:0]                   hit_k;
  logic [AW-1:0]                   hit_addr;
  logic [KW-1:0]                   next_base;
  logic                            scan_end;

  // count step unit
  logic [COUNT_WIDTH-1:0]          cnt_rd;
  logic [COUNT_WIDTH-1:0]          cnt_delta;
  logic [COUNT_WIDTH-1:0]          cnt_sum;
  logic                            cnt_sat;
  logic [COUNT_WIDTH-1:0]          cnt_step;

  // memory ports
  logic                            desc_we;
  logic                            desc_re;
  logic [dsa_pkg::DESC_W-1:0]      desc_rdata;
  logic                            cnt_we;
  logic                            cnt_re;
  logic [AW-1:0]                   cnt_waddr;
  logic [COUNT_WIDTH-1:0]          cnt_wdata;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign lim      = (LW'(limit_r) > LW'(SLOTS_PER_INTERFACE)) ?
                    LW'(SLOTS_PER_INTERFACE) : LW'(limit_r);
  assign iface_ok = ({1'b0, iface_r} < (dsa_pkg::IFACE_W + 1)'(NUM_INTERFACES));
  assign en_vec   = {{dsa_pkg::ENABLE_W{1'b0}}, en_mask_r};
  assign enabled  = en_vec[iface_r];
  assign base     = AW'(iface_r[IW-1:0]) * AW'(SLOTS_PER_INTERFACE);
  assign idx      = AW'(XW'(base) + XW'(slot_r));
  assign slot_ok  = LW'(slot_r) < lim;
  assign opts_bad = |(opts_r & ~opt_mask_r);

  // Free-slot scanner: one group of busy bits per cycle, lowest free slot wins.
  always_comb begin
    scan_free = '0;
    hit_j     = '0;
    for (int j = 0; j < dsa_pkg::CHUNK; j++) begin
      scan_k[j]    = (KW'(chunk_r) << CSH) | KW'(j);
      scan_free[j] = (scan_k[j] < KW'(lim)) &&
                     !busy_r[AW'(XW'(base) + XW'(scan_k[j]))];
    end
    for (int j = dsa_pkg::CHUNK - 1; j >= 0; j--) begin
      if (scan_free[j]) begin
        hit_j = CSH'(j);
      end
    end
  end

  assign scan_hit  = |scan_free;
  assign hit_k     = (KW'(chunk_r) << CSH) | KW'(hit_j);
  assign hit_addr  = AW'(XW'(base) + XW'(hit_k));
  assign next_base = (KW'(chunk_r) + KW'(1)) << CSH;
  assign scan_end  = next_base >= KW'(lim);

  // Saturating count step: one adder, increment for post, decrement for clear.
  assign cnt_delta = (action_r == dsa_pkg::ACT_POST) ? COUNT_WIDTH'(1) : COUNT_MAX;
  assign cnt_sum   = cnt_rd + cnt_delta;
  assign cnt_sat   = (action_r == dsa_pkg::ACT_POST) ? (cnt_rd == COUNT_MAX) :
                                                       (cnt_rd == '0);
  assign cnt_step  = cnt_sat ? cnt_rd : cnt_sum;

  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt      = state_r;
    chunk_nxt      = chunk_r;
    busy_nxt       = busy_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_fetch_nxt  = res_fetch_r;
    desc_we        = 1'b0;
    desc_re        = 1'b0;
    cnt_we         = 1'b0;
    cnt_re         = 1'b0;
    cnt_waddr      = idx;
    cnt_wdata      = cnt_step;
    out_valid_nxt  = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        res_fetch_nxt = 1'b0;
        if (in_xfer) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        chunk_nxt    = '0;
        res_slot_nxt = slot_r;
        state_nxt    = S_DONE;
        priority if (action_r > dsa_pkg::ACT_CLEAR || !iface_ok || !kind_ok_r) begin
          res_status_nxt = dsa_pkg::ST_INVALID;
          if (action_r == dsa_pkg::ACT_BIND) res_slot_nxt = '0;
        end else if (!enabled) begin
          res_status_nxt = (action_r <= dsa_pkg::ACT_VALIDATE) ?
                           dsa_pkg::ST_INVALID : dsa_pkg::ST_ABSENT;
          if (action_r == dsa_pkg::ACT_BIND) res_slot_nxt = '0;
        end else if (action_r == dsa_pkg::ACT_BIND) begin
          res_slot_nxt = '0;
          if (opts_bad) begin
            res_status_nxt = dsa_pkg::ST_INVALID;
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (!slot_ok) begin
          res_status_nxt = dsa_pkg::ST_INVALID;
        end else if (action_r == dsa_pkg::ACT_FETCH) begin
          desc_re        = 1'b1;
          res_fetch_nxt  = 1'b1;
          res_status_nxt = dsa_pkg::ST_OK;
        end else if (!busy_r[idx]) begin
          res_status_nxt = dsa_pkg::ST_INVALID;
        end else if (action_r == dsa_pkg::ACT_VALIDATE) begin
          res_status_nxt = dsa_pkg::ST_OK;
        end else begin
          cnt_re    = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          desc_we            = 1'b1;
          cnt_we             = 1'b1;
          cnt_waddr          = hit_addr;
          cnt_wdata          = '0;
          busy_nxt[hit_addr] = 1'b1;
          res_status_nxt     = dsa_pkg::ST_OK;
          res_slot_nxt       = hit_k[dsa_pkg::SLOT_W-1:0];
          state_nxt          = S_DONE;
        end else if (scan_end) begin
          res_status_nxt = dsa_pkg::ST_NO_SPACE;
          state_nxt      = S_DONE;
        end else begin
          chunk_nxt = chunk_r + CW'(1);
        end
      end
      S_READ: begin
        res_status_nxt = dsa_pkg::ST_OK;
        state_nxt      = S_DONE;
        if (action_r == dsa_pkg::ACT_RELEASE) begin
          if (cnt_rd != '0) begin
            res_status_nxt = dsa_pkg::ST_INVALID;
          end else begin
            busy_nxt[idx] = 1'b0;
          end
        end else begin
          cnt_we = 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chunk_r     <= '0;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
      en_mask_r   <= '0;
      limit_r     <= dsa_pkg::LIMIT_RESET;
      opt_mask_r  <= dsa_pkg::OPTIONS_RESET;
    end else begin
      state_r     <= state_nxt;
      chunk_r     <= chunk_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        priority case (cfg_index)
          dsa_pkg::CFG_ENABLE_MASK:  en_mask_r  <= cfg_wdata[dsa_pkg::ENABLE_W-1:0];
          dsa_pkg::CFG_SLOT_LIMIT:   limit_r    <= cfg_wdata[dsa_pkg::LIMIT_W-1:0];
          dsa_pkg::CFG_OPTIONS_MASK: opt_mask_r <= cfg_wdata[dsa_pkg::OPTIONS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_fetch_r  <= res_fetch_nxt;
    if (in_xfer) begin
      action_r  <= dsa_pkg::action_t'(in_action);
      iface_r   <= in_interface_req;
      kind_ok_r <= in_handle_kind_ok;
      slot_r    <= in_slot;
      start_r   <= in_start_address;
      length_r  <= in_buffer_length;
      opts_r    <= in_option_bits;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      // Drop the read data unless this transfer is a successful fetch.
      if (res_fetch_r) begin
        {out_start_r, out_length_r, out_options_r} <= desc_rdata;
      end else begin
        out_start_r   <= '0;
        out_length_r  <= '0;
        out_options_r <= '0;
      end
    end
  end

  dsa_ram #(
    .WIDTH (dsa_pkg::DESC_W),
    .DEPTH (TOTAL)
  ) u_desc_ram (
    .clk   (clk),
    .we    (desc_we),
    .waddr (hit_addr),
    .wdata ({start_r, length_r, opts_r}),
    .re    (desc_re),
    .raddr (idx),
    .rdata (desc_rdata)
  );

  dsa_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (TOTAL)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (idx),
    .rdata (cnt_rd)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_assigned_slot = out_slot_r;
  assign out_read_start    = out_start_r;
  assign out_read_length   = out_length_r;
  assign out_read_options  = out_options_r;

  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_CHECK))
    else $error("accepted item did not enter the check step");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result presented without finishing the sequence");

  a_grant_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_hit) |-> (hit_k < KW'(lim)))
    else $error("bind granted a slot beyond the usable limit");

  a_grant_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_hit) |=> busy_r[$past(hit_addr)])
    else $error("granted slot not marked in use");

endmodule

`default_nettype wire

// ===== tb/descriptor_slot_allocator_tb.sv =====
// Self-checking testbench for the descriptor slot allocator: directed cases, then random traffic.
module descriptor_slot_allocator_tb;

  localparam int N_IF      = 4;
  localparam int SLOTS     = 64;
  localparam int COUNT_W   = 16;
  localparam int TOTAL     = N_IF * SLOTS;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_OPS   = 100;

  localparam logic [COUNT_W-1:0]   COUNT_MAX      = '1;
  localparam logic [2:0]           ACT_UNKNOWN_LO = 3'd6;
  localparam logic [2:0]           ACT_UNKNOWN_HI = 3'd7;
  localparam logic [dsa_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct {
    logic [2:0]                    action;
    logic [dsa_pkg::IFACE_W-1:0]   iface;
    logic                          kind_ok;
    logic [dsa_pkg::SLOT_W-1:0]    slot;
    logic [dsa_pkg::ADDR64_W-1:0]  start_addr;
    logic [dsa_pkg::ADDR64_W-1:0]  buf_len;
    logic [dsa_pkg::OPTIONS_W-1:0] opts;
  } table_op_t;

  typedef struct {
    dsa_pkg::status_t              status;
    logic [dsa_pkg::SLOT_W-1:0]    slot;
    logic [dsa_pkg::ADDR64_W-1:0]  rd_start;
    logic [dsa_pkg::ADDR64_W-1:0]  rd_len;
    logic [dsa_pkg::OPTIONS_W-1:0] rd_opts;
  } table_outcome_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [2:0]                     in_action = '0;
  logic [dsa_pkg::IFACE_W-1:0]    in_interface_req = '0;
  logic                           in_handle_kind_ok = 1'b0;
  logic [dsa_pkg::SLOT_W-1:0]     in_slot = '0;
  logic [dsa_pkg::ADDR64_W-1:0]   in_start_address = '0;
  logic [dsa_pkg::ADDR64_W-1:0]   in_buffer_length = '0;
  logic [dsa_pkg::OPTIONS_W-1:0]  in_option_bits = '0;

  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [1:0]                     out_status;
  logic [dsa_pkg::SLOT_W-1:0]     out_assigned_slot;
  logic [dsa_pkg::ADDR64_W-1:0]   out_read_start;
  logic [dsa_pkg::ADDR64_W-1:0]   out_read_length;
  logic [dsa_pkg::OPTIONS_W-1:0]  out_read_options;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [dsa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dsa_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // mirror of the slot tables and registers
  bit                            slot_in_use  [TOTAL];
  bit                            slot_written [TOTAL];
  bit [COUNT_W-1:0]              slot_refs    [TOTAL];
  bit [dsa_pkg::ADDR64_W-1:0]    slot_start   [TOTAL];
  bit [dsa_pkg::ADDR64_W-1:0]    slot_len     [TOTAL];
  bit [dsa_pkg::OPTIONS_W-1:0]   slot_opts    [TOTAL];
  bit [dsa_pkg::ENABLE_W-1:0]    iface_enable = '0;
  bit [dsa_pkg::LIMIT_W-1:0]     slot_cap     = dsa_pkg::LIMIT_RESET;
  bit [dsa_pkg::OPTIONS_W-1:0]   opt_allow    = dsa_pkg::OPTIONS_RESET;

  table_outcome_t outcome_q[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int op_count = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int binds_granted = 0;
  int tables_full = 0;

  descriptor_slot_allocator #(
    .NUM_INTERFACES(N_IF),
    .SLOTS_PER_INTERFACE(SLOTS),
    .COUNT_WIDTH(COUNT_W)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_interface_req(in_interface_req),
    .in_handle_kind_ok(in_handle_kind_ok),
    .in_slot(in_slot),
    .in_start_address(in_start_address),
    .in_buffer_length(in_buffer_length),
    .in_option_bits(in_option_bits),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_assigned_slot(out_assigned_slot),
    .out_read_start(out_read_start),
    .out_read_length(out_read_length),
    .out_read_options(out_read_options),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int usable_limit();
    return (slot_cap > SLOTS) ? SLOTS : int'(slot_cap);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic table_outcome_t table_outcome(input table_op_t op);
    table_outcome_t res;
    int lim;
    int idx;
    int k;
    res.status = dsa_pkg::ST_OK;
    res.slot = op.slot;
    res.rd_start = '0;
    res.rd_len = '0;
    res.rd_opts = '0;
    lim = usable_limit();
    if (op.action > dsa_pkg::ACT_CLEAR || op.iface >= N_IF || !op.kind_ok) begin
      res.status = dsa_pkg::ST_INVALID;
      if (op.action == dsa_pkg::ACT_BIND) res.slot = '0;
      return res;
    end
    if (!iface_enable[op.iface]) begin
      if (op.action <= dsa_pkg::ACT_VALIDATE) res.status = dsa_pkg::ST_INVALID;
      else res.status = dsa_pkg::ST_ABSENT;
      if (op.action == dsa_pkg::ACT_BIND) res.slot = '0;
      return res;
    end
    if (op.action == dsa_pkg::ACT_BIND) begin
      res.slot = '0;
      if ((op.opts & ~opt_allow) != '0) begin
        res.status = dsa_pkg::ST_INVALID;
        return res;
      end
      res.status = dsa_pkg::ST_NO_SPACE;
      for (k = 0; k < lim; k++) begin
        idx = op.iface * SLOTS + k;
        if (!slot_in_use[idx]) begin
          slot_in_use[idx] = 1'b1;
          slot_written[idx] = 1'b1;
          slot_refs[idx] = '0;
          slot_start[idx] = op.start_addr;
          slot_len[idx] = op.buf_len;
          slot_opts[idx] = op.opts;
          res.slot = dsa_pkg::SLOT_W'(k);
          res.status = dsa_pkg::ST_OK;
          binds_granted++;
          return res;
        end
      end
      tables_full++;
      return res;
    end
    if (op.slot >= lim) begin
      res.status = dsa_pkg::ST_INVALID;
      return res;
    end
    idx = op.iface * SLOTS + op.slot;
    if (op.action == dsa_pkg::ACT_FETCH) begin
      res.rd_start = slot_start[idx];
      res.rd_len = slot_len[idx];
      res.rd_opts = slot_opts[idx];
      return res;
    end
    if (!slot_in_use[idx]) begin
      res.status = dsa_pkg::ST_INVALID;
      return res;
    end
    case (op.action)
      dsa_pkg::ACT_RELEASE: begin
        if (slot_refs[idx] != '0) res.status = dsa_pkg::ST_INVALID;
        else slot_in_use[idx] = 1'b0;
      end
      // saturate at both ends
      dsa_pkg::ACT_POST: begin
        if (slot_refs[idx] != COUNT_MAX) slot_refs[idx] = slot_refs[idx] + 1'b1;
      end
      dsa_pkg::ACT_CLEAR: begin
        if (slot_refs[idx] != '0) slot_refs[idx] = slot_refs[idx] - 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic table_op_t make_op(input logic [2:0] act,
                                        input logic [dsa_pkg::IFACE_W-1:0] ifc,
                                        input logic [dsa_pkg::SLOT_W-1:0] slt);
    table_op_t op;
    op.action = act;
    op.iface = ifc;
    op.kind_ok = 1'b1;
    op.slot = slt;
    op.start_addr = {$urandom, $urandom};
    op.buf_len = {$urandom, $urandom};
    op.opts = dsa_pkg::OPTIONS_W'($urandom);
    return op;
  endfunction

  function automatic table_op_t random_op();
    table_op_t op;
    int lim;
    int r;
    int idx;
    int k;
    int cands[$];
    op = make_op(dsa_pkg::ACT_VALIDATE, dsa_pkg::IFACE_W'($urandom_range(0, N_IF - 1)),
                 dsa_pkg::SLOT_W'($urandom));
    lim = usable_limit();
    if ($urandom_range(0, 99) < 12) begin
      // noise: any action, any interface, either handle kind
      op.action = 3'($urandom);
      op.iface = dsa_pkg::IFACE_W'($urandom);
      op.kind_ok = 1'($urandom);
    end else begin
      for (k = 0; k < N_IF; k++)
        if (iface_enable[k]) cands.push_back(k);
      if (cands.size() != 0)
        op.iface = dsa_pkg::IFACE_W'(cands[$urandom_range(0, cands.size() - 1)]);
      cands.delete();
      r = $urandom_range(0, 99);
      if (r < 25) op.action = dsa_pkg::ACT_BIND;
      else if (r < 45) op.action = dsa_pkg::ACT_RELEASE;
      else if (r < 55) op.action = dsa_pkg::ACT_VALIDATE;
      else if (r < 70) op.action = dsa_pkg::ACT_FETCH;
      else if (r < 85) op.action = dsa_pkg::ACT_POST;
      else op.action = dsa_pkg::ACT_CLEAR;
      if (op.action == dsa_pkg::ACT_BIND) begin
        if ($urandom_range(0, 4) != 0) op.opts = op.opts & opt_allow;
      end else begin
        for (k = 0; k < lim; k++) begin
          idx = op.iface * SLOTS + k;
          if (op.action == dsa_pkg::ACT_FETCH ? slot_written[idx] : slot_in_use[idx])
            cands.push_back(k);
        end
        if (cands.size() != 0 && $urandom_range(0, 3) != 0)
          op.slot = dsa_pkg::SLOT_W'(cands[$urandom_range(0, cands.size() - 1)]);
        else if (lim != 0 && $urandom_range(0, 4) != 0)
          op.slot = dsa_pkg::SLOT_W'($urandom_range(0, lim - 1));
      end
    end
    // keep fetches off entries that were never bound
    if (op.action == dsa_pkg::ACT_FETCH && op.iface < N_IF && op.kind_ok &&
        iface_enable[op.iface] && op.slot < lim && !slot_written[op.iface * SLOTS + op.slot])
      op.action = dsa_pkg::ACT_VALIDATE;
    return op;
  endfunction

  task automatic send_op(input table_op_t op);
    int gap;
    in_valid <= 1'b1;
    in_action <= op.action;
    in_interface_req <= op.iface;
    in_handle_kind_ok <= op.kind_ok;
    in_slot <= op.slot;
    in_start_address <= op.start_addr;
    in_buffer_length <= op.buf_len;
    in_option_bits <= op.opts;
    do @(posedge clk); while (in_stall);
    outcome_q.push_back(table_outcome(op));
    op_count++;
    gap = pick_gap(gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and let every pending result drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [dsa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dsa_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dsa_pkg::CFG_ENABLE_MASK:  iface_enable = data[dsa_pkg::ENABLE_W-1:0];
      dsa_pkg::CFG_SLOT_LIMIT:   slot_cap = data[dsa_pkg::LIMIT_W-1:0];
      dsa_pkg::CFG_OPTIONS_MASK: opt_allow = data[dsa_pkg::OPTIONS_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    table_outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        $error("result transfer with no operation outstanding");
        fail_count++;
      end else begin
        want = outcome_q.pop_front();
        check_field("status", want.status, out_status);
        check_field("assigned_slot", want.slot, out_assigned_slot);
        check_field("read_start", want.rd_start, out_read_start);
        check_field("read_length", want.rd_len, out_read_length);
        check_field("read_options", want.rd_opts, out_read_options);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    int hold;
    if (hold == 0) hold = pick_gap(stall_pct);
    if (hold > 0) begin
      out_stall <= 1'b1;
      hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL descriptor_slot_allocator");
    $finish;
  end

  // Tables start disabled: every action is turned away; then malformed handles.
  task automatic test_disabled_tables();
    table_op_t op;
    gap_pct = 20;
    stall_pct = 20;
    send_op(make_op(dsa_pkg::ACT_BIND, 3'd0, 6'd0));
    send_op(make_op(dsa_pkg::ACT_RELEASE, 3'd1, 6'd5));
    send_op(make_op(dsa_pkg::ACT_VALIDATE, 3'd2, 6'd63));
    send_op(make_op(dsa_pkg::ACT_FETCH, 3'd3, 6'd0));
    send_op(make_op(dsa_pkg::ACT_POST, 3'd0, 6'd1));
    send_op(make_op(dsa_pkg::ACT_CLEAR, 3'd1, 6'd2));
    wait_idle();
    cfg_write(dsa_pkg::CFG_ENABLE_MASK, 16'hFFFF);
    send_op(make_op(dsa_pkg::ACT_VALIDATE, 3'd4, 6'd0));
    send_op(make_op(dsa_pkg::ACT_BIND, 3'd7, 6'd0));
    op = make_op(dsa_pkg::ACT_BIND, 3'd0, 6'd0);
    op.kind_ok = 1'b0;
    send_op(op);
    send_op(make_op(ACT_UNKNOWN_LO, 3'd0, 6'd0));
    send_op(make_op(ACT_UNKNOWN_HI, 3'd1, 6'd0));
  endtask

  task automatic test_bind_release();
    table_op_t op;
    op = make_op(dsa_pkg::ACT_BIND, 3'd0, 6'd0);
    op.start_addr = '1;
    op.buf_len = '1;
    op.opts = '1;
    send_op(op);
    op.start_addr = '0;
    op.buf_len = '0;
    op.opts = '0;
    send_op(op);
    send_op(make_op(dsa_pkg::ACT_FETCH, 3'd0, 6'd0));
    send_op(make_op(dsa_pkg::ACT_FETCH, 3'd0, 6'd1));
    send_op(make_op(dsa_pkg::ACT_POST, 3'd0, 6'd0));
    send_op(make_op(dsa_pkg::ACT_RELEASE, 3'd0, 6'd0));
    send_op(make_op(dsa_pkg::ACT_CLEAR, 3'd0, 6'd0));
    send_op(make_op(dsa_pkg::ACT_CLEAR, 3'd0, 6'd0));
    send_op(make_op(dsa_pkg::ACT_RELEASE, 3'd0, 6'd0));
    send_op(make_op(dsa_pkg::ACT_RELEASE, 3'd0, 6'd0));
    send_op(make_op(dsa_pkg::ACT_POST, 3'd0, 6'd0));
    send_op(make_op(dsa_pkg::ACT_BIND, 3'd0, 6'd0));
  endtask

  task automatic test_limits_and_options();
    table_op_t op;
    wait_idle();
    cfg_write(dsa_pkg::CFG_SLOT_LIMIT, 16'd2);
    repeat (3) send_op(make_op(dsa_pkg::ACT_BIND, 3'd1, 6'd0));
    send_op(make_op(dsa_pkg::ACT_VALIDATE, 3'd1, 6'd2));
    send_op(make_op(dsa_pkg::ACT_FETCH, 3'd1, 6'd63));
    wait_idle();
    cfg_write(dsa_pkg::CFG_SLOT_LIMIT, 16'd0);
    send_op(make_op(dsa_pkg::ACT_BIND, 3'd1, 6'd0));
    send_op(make_op(dsa_pkg::ACT_VALIDATE, 3'd1, 6'd0));
    wait_idle();
    // 7-bit register: 127 is clamped to the table size
    cfg_write(dsa_pkg::CFG_SLOT_LIMIT, 16'hFFFF);
    send_op(make_op(dsa_pkg::ACT_BIND, 3'd1, 6'd0));
    wait_idle();
    cfg_write(dsa_pkg::CFG_OPTIONS_MASK, 16'h00F0);
    op = make_op(dsa_pkg::ACT_BIND, 3'd1, 6'd0);
    op.opts = 16'h0100;
    send_op(op);
    op.opts = 16'h00F0;
    send_op(op);
    wait_idle();
    cfg_write(dsa_pkg::CFG_OPTIONS_MASK, 16'h0000);
    op.opts = 16'h0000;
    send_op(op);
    op.opts = 16'h8000;
    send_op(op);
    wait_idle();
    cfg_write(CFG_UNUSED_IDX, dsa_pkg::CFG_DATA_W'($urandom));
    cfg_write(dsa_pkg::CFG_OPTIONS_MASK, dsa_pkg::OPTIONS_RESET);
    cfg_write(dsa_pkg::CFG_SLOT_LIMIT, 16'd64);
    send_op(make_op(dsa_pkg::ACT_VALIDATE, 3'd1, 6'd0));
  endtask

  // Step one count up, hold release off while it is referenced, then clear past zero.
  task automatic test_count_saturation();
    int i;
    wait_idle();
    gap_pct = 0;
    stall_pct = 0;
    send_op(make_op(dsa_pkg::ACT_BIND, 3'd2, 6'd0));
    for (i = 0; i < 3; i++) send_op(make_op(dsa_pkg::ACT_POST, 3'd2, 6'd0));
    send_op(make_op(dsa_pkg::ACT_VALIDATE, 3'd2, 6'd0));
    send_op(make_op(dsa_pkg::ACT_RELEASE, 3'd2, 6'd0));
    for (i = 0; i < 5; i++) send_op(make_op(dsa_pkg::ACT_CLEAR, 3'd2, 6'd0));
    send_op(make_op(dsa_pkg::ACT_RELEASE, 3'd2, 6'd0));
  endtask

  task automatic test_random_traffic();
    int phase;
    int pcts[4] = '{0, 10, 30, 60};
    logic [dsa_pkg::CFG_DATA_W-1:0] data;
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: data = 16'h0000;
        1, 2, 3, 4: data = 16'h000F;
        default: data = dsa_pkg::CFG_DATA_W'($urandom);
      endcase
      cfg_write(dsa_pkg::CFG_ENABLE_MASK, data);
      case ($urandom_range(0, 6))
        0: data = 16'd0;
        1: data = 16'd1;
        2: data = 16'd3;
        3: data = 16'd8;
        4: data = 16'd64;
        5: data = 16'd127;
        default: data = dsa_pkg::CFG_DATA_W'($urandom);
      endcase
      cfg_write(dsa_pkg::CFG_SLOT_LIMIT, data);
      case ($urandom_range(0, 3))
        0: data = 16'h0000;
        1: data = dsa_pkg::CFG_DATA_W'($urandom);
        default: data = 16'hFFFF;
      endcase
      cfg_write(dsa_pkg::CFG_OPTIONS_MASK, data);
      // first phase runs with no idling on either side
      gap_pct = (phase == 0) ? 0 : pcts[$urandom_range(0, 3)];
      stall_pct = (phase == 0) ? 0 : pcts[$urandom_range(0, 3)];
      repeat (PHASE_OPS) send_op(random_op());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_disabled_tables();
    test_bind_release();
    test_limits_and_options();
    test_count_saturation();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk);
    $display("Sent %0d operations over %0d register writes; %0d results checked.",
             op_count, cfg_writes, results_checked);
    $display("Binds granted: %0d, binds refused on a full table: %0d.",
             binds_granted, tables_full);
    if (fail_count == 0) begin
      $display("PASS descriptor_slot_allocator");
    end else begin
      $display("FAIL descriptor_slot_allocator");
    end
    $finish;
  end

endmodule
